FILE: rtl/tpsp_pkg.sv
// ----------------------------------------------------------------------------
// tpsp_pkg: shared types and constants of the teach-and-playback positioner
// Holds the mode codes, coil patterns, register indexes, reset values and
// the structures that travel between the control core and the result pipe.
// ----------------------------------------------------------------------------
package tpsp_pkg;

    // Operating modes: three teach steps, a wait for run, three playback poses.
    typedef enum logic [2:0] {
        MODE_TEACH0 = 3'd0,
        MODE_TEACH1 = 3'd1,
        MODE_TEACH2 = 3'd2,
        MODE_WAIT   = 3'd3,
        MODE_PLAY0  = 3'd4,
        MODE_PLAY1  = 3'd5,
        MODE_PLAY2  = 3'd6
    } t_mode;

    // Mode code shown on the result while the block is halted.
    localparam logic [2:0] MODE_SHOWN_HALTED = 3'd7;

    // Four-phase full-step coil patterns, bit 3 drives the first pin.
    localparam logic [3:0] PH_A = 4'b1100;
    localparam logic [3:0] PH_B = 4'b1001;
    localparam logic [3:0] PH_C = 4'b0011;
    localparam logic [3:0] PH_D = 4'b0110;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEADBAND   = 2'd0;
    localparam logic [1:0] CFG_MIN_DELAY  = 2'd1;
    localparam logic [1:0] CFG_DIVISOR    = 2'd2;

    // Reset values.
    localparam logic [3:0] DEADBAND_RST   = 4'd5;
    localparam logic [5:0] MIN_DELAY_RST  = 6'd9;
    localparam logic [7:0] DIVISOR_RST    = 8'd30;
    localparam logic [5:0] DELAY_RST      = 6'd15;
    localparam logic [5:0] SPEED_MAX      = 6'd63;

    // One input item.
    typedef struct packed {
        logic [9:0] pot_one;
        logic [9:0] pot_two;
        logic [9:0] pot_three;
        logic       save_level;
        logic       run_level;
        logic       stop_level;
    } t_item;

    // Result fields settled by the control core.
    typedef struct packed {
        logic [3:0] coils_one;
        logic [3:0] coils_two;
        logic [3:0] coils_three;
        logic [2:0] lamps;
        logic       gripper_closed;
        logic [2:0] mode_now;
        logic [2:0] arrived_mask;
    } t_res;

    // Control core to result pipe: settled fields plus the speed request.
    typedef struct packed {
        t_res       res;
        logic       upd;
        logic [9:0] speed;
    } t_tick;

    // One stage of the speed divider pipe.
    typedef struct packed {
        t_res       res;
        logic       upd;
        logic [9:0] rem;
        logic [5:0] quo;
        logic       sat;
    } t_stage;

endpackage

FILE: rtl/tpsp_if.sv
// ----------------------------------------------------------------------------
// tpsp_if: channel interfaces of the teach-and-playback positioner
// Input item channel, result item channel and configuration write channel,
// each with valid and ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface tpsp_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] pot_one;
    logic [9:0] pot_two;
    logic [9:0] pot_three;
    logic       save_level;
    logic       run_level;
    logic       stop_level;

    modport source (output valid, pot_one, pot_two, pot_three, save_level,
                    run_level, stop_level, input ready);
    modport sink   (input valid, pot_one, pot_two, pot_three, save_level,
                    run_level, stop_level, output ready);
endinterface

interface tpsp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coils_one;
    logic [3:0] coils_two;
    logic [3:0] coils_three;
    logic [5:0] step_delay_ms;
    logic [2:0] lamps;
    logic       gripper_closed;
    logic [2:0] mode_now;
    logic [2:0] arrived_mask;

    modport source (output valid, coils_one, coils_two, coils_three, step_delay_ms,
                    lamps, gripper_closed, mode_now, arrived_mask, input ready);
    modport sink   (input valid, coils_one, coils_two, coils_three, step_delay_ms,
                    lamps, gripper_closed, mode_now, arrived_mask, output ready);
endinterface

interface tpsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tpsp_ctrl.sv
// ----------------------------------------------------------------------------
// tpsp_ctrl: mode machine and axis state of the positioner
// Holds mode, halt flag, axis positions, coil phases, taught poses and the
// lamp, gripper and arrival flags. Each accepted item updates them and
// hands the settled result fields to the result pipe.
// ----------------------------------------------------------------------------
module tpsp_ctrl #(
    parameter int AXES       = 3,
    parameter int POSE_SLOTS = 3,
    parameter int POS_BITS   = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  tpsp_pkg::t_item i_item,
    input  logic [3:0]     i_deadband,
    output tpsp_pkg::t_tick o_tick
);
    import tpsp_pkg::*;

    localparam int SLOT_W = (POSE_SLOTS > 1) ? $clog2(POSE_SLOTS) : 1;
    localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

    // State.
    t_mode                            r_mode,   n_mode;
    logic                             r_halted, n_halted;
    logic [AXES-1:0][POS_BITS-1:0]    r_pos,    n_pos;
    logic [AXES-1:0][3:0]             r_phase,  n_phase;
    logic [AXES-1:0]                  r_arr,    n_arr;
    logic                             r_servo,  n_servo;
    logic [2:0]                       r_lamp,   n_lamp;
    logic [AXES-1:0][POS_BITS-1:0]    r_pose [POSE_SLOTS];

    // Working signals of the tick.
    logic                             all_arr;
    logic                             store_en;
    logic [2:0]                       store_slot;
    logic                             teach_move;
    logic                             pose_move;
    logic                             upd;
    logic [2:0]                       slot_raw;
    logic [SLOT_W-1:0]                rd_slot;
    logic [AXES+2:0][9:0]             pots_pad;
    logic [AXES-1:0][POS_BITS-1:0]    tgt;
    logic [AXES-1:0][POS_BITS+4:0]    mv;
    logic [4*AXES+11:0]               ph_flat;
    logic [AXES+2:0]                  arr_pad;

    // Reset coil pattern of an axis.
    function automatic logic [3:0] f_phase_rst(input int a);
        logic [3:0] ph;
        if (a % 3 == 0) begin
            ph = PH_D;
        end else if (a % 3 == 1) begin
            ph = PH_C;
        end else begin
            ph = PH_A;
        end
        return ph;
    endfunction

    // One axis: arrival check, else one full step toward the target.
    // Returns {arrived, phase, position}.
    function automatic logic [POS_BITS+4:0] f_move(
        input logic [POS_BITS-1:0] pos,
        input logic [POS_BITS-1:0] target,
        input logic [3:0]          ph,
        input logic [3:0]          db
    );
        logic [POS_BITS-1:0] diff;
        logic [POS_BITS-1:0] npos;
        logic [3:0]          nph;
        logic                fwd;
        logic                arr;
        diff = (pos > target) ? (pos - target) : (target - pos);
        fwd  = (pos < target);
        npos = pos;
        nph  = ph;
        arr  = 1'b0;
        if (diff <= POS_BITS'(db)) begin
            arr = 1'b1;
        end else begin
            case (ph)
                PH_A: nph = fwd ? PH_B : PH_D;
                PH_B: nph = fwd ? PH_C : PH_A;
                PH_C: nph = fwd ? PH_D : PH_B;
                PH_D: nph = fwd ? PH_A : PH_C;
                default: nph = PH_A;
            endcase
            // An odd pattern is only replaced, the axis does not move.
            if (ph == PH_A || ph == PH_B || ph == PH_C || ph == PH_D) begin
                npos = fwd ? (pos + POS_ONE) : (pos - POS_ONE);
            end
        end
        return {arr, nph, npos};
    endfunction

    assign all_arr  = &r_arr;
    assign pots_pad = {{(AXES*10){1'b0}}, i_item.pot_three, i_item.pot_two,
                       i_item.pot_one};

    // Mode transition, then the action of the new mode.
    always_comb begin
        n_mode     = r_mode;
        n_halted   = r_halted;
        n_servo    = r_servo;
        n_lamp     = r_lamp;
        n_arr      = r_arr;
        store_en   = 1'b0;
        store_slot = 3'd0;
        teach_move = 1'b0;
        pose_move  = 1'b0;
        upd        = 1'b0;
        if (r_halted) begin
            if (i_item.run_level) begin
                n_halted = 1'b0;
                if (r_mode == MODE_PLAY0 || r_mode == MODE_PLAY1 ||
                    r_mode == MODE_PLAY2) begin
                    pose_move = 1'b1;
                end
            end
        end else begin
            case (r_mode)
                MODE_TEACH0: if (i_item.save_level) begin
                    n_mode     = MODE_TEACH1;
                    store_en   = 1'b1;
                    store_slot = 3'd0;
                end
                MODE_TEACH1: if (!i_item.save_level) begin
                    n_mode     = MODE_TEACH2;
                    store_en   = 1'b1;
                    store_slot = 3'd1;
                end
                MODE_TEACH2: if (i_item.save_level) begin
                    n_mode     = MODE_WAIT;
                    store_en   = 1'b1;
                    store_slot = 3'd2;
                end
                MODE_WAIT: if (i_item.run_level) begin
                    n_mode = MODE_PLAY0;
                    n_arr  = '0;
                end
                MODE_PLAY0: if (all_arr) begin
                    n_servo = 1'b0;
                    n_mode  = MODE_PLAY1;
                    n_arr   = '0;
                end
                MODE_PLAY1: if (all_arr) begin
                    n_mode = MODE_PLAY2;
                    n_arr  = '0;
                end
                MODE_PLAY2: if (all_arr) begin
                    n_servo = 1'b1;
                    n_mode  = MODE_PLAY0;
                    n_arr   = '0;
                end
                default: n_mode = MODE_TEACH0;
            endcase

            case (n_mode)
                MODE_TEACH0, MODE_TEACH1, MODE_TEACH2: begin
                    n_lamp     = n_mode;
                    teach_move = 1'b1;
                end
                MODE_WAIT: begin
                    n_lamp = r_lamp ^ 3'b111;
                end
                MODE_PLAY0, MODE_PLAY1, MODE_PLAY2: begin
                    n_lamp = n_mode;
                    upd    = 1'b1;
                    if (i_item.stop_level && !i_item.run_level) begin
                        n_halted = 1'b1;
                    end else begin
                        pose_move = 1'b1;
                    end
                end
                default: n_lamp = r_lamp;
            endcase
        end

        // Pose slot of the current playback mode.
        slot_raw = n_mode - 3'd4;
        rd_slot  = (int'(slot_raw) < POSE_SLOTS) ? slot_raw[SLOT_W-1:0] : '0;

        // Per-axis targets and moves.
        n_pos   = r_pos;
        n_phase = r_phase;
        for (int a = 0; a < AXES; a++) begin
            tgt[a] = teach_move ? POS_BITS'({pots_pad[a], 1'b0}) : r_pose[rd_slot][a];
            mv[a]  = f_move(r_pos[a], tgt[a], r_phase[a], i_deadband);
            if (teach_move || pose_move) begin
                n_pos[a]   = mv[a][POS_BITS-1:0];
                n_phase[a] = mv[a][POS_BITS+3:POS_BITS];
                n_arr[a]   = n_arr[a] | mv[a][POS_BITS+4];
            end
        end
    end

    // Result fields from the state after the tick.
    assign ph_flat = {12'b0, n_phase};
    assign arr_pad = {3'b0, n_arr};

    always_comb begin
        o_tick.res.coils_one      = ph_flat[3:0];
        o_tick.res.coils_two      = ph_flat[7:4];
        o_tick.res.coils_three    = ph_flat[11:8];
        o_tick.res.lamps          = n_halted ? 3'd0 : n_lamp;
        o_tick.res.gripper_closed = n_servo;
        o_tick.res.mode_now       = n_halted ? MODE_SHOWN_HALTED : n_mode;
        o_tick.res.arrived_mask   = arr_pad[2:0];
        o_tick.upd                = upd;
        o_tick.speed              = i_item.pot_one;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_TEACH0;
            r_halted <= 1'b0;
            r_arr    <= '0;
            r_servo  <= 1'b0;
            r_lamp   <= 3'd0;
            r_pos    <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_phase[a] <= f_phase_rst(a);
            end
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_halted <= n_halted;
            r_arr    <= n_arr;
            r_servo  <= n_servo;
            r_lamp   <= n_lamp;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
        end
    end

    // Taught poses take the positions held before the tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < POSE_SLOTS; s++) begin
                r_pose[s] <= '0;
            end
        end else if (i_accept && store_en && (int'(store_slot) < POSE_SLOTS)) begin
            r_pose[store_slot[SLOT_W-1:0]] <= r_pos;
        end
    end

endmodule

FILE: rtl/tpsp_pipe.sv
// ----------------------------------------------------------------------------
// tpsp_pipe: speed divider and result register
// Carries the settled result fields through three stages while the speed
// sample is divided two quotient bits per stage, then fixes the step delay
// and holds the result item until it is taken. Stages close up over bubbles.
// ----------------------------------------------------------------------------
module tpsp_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  tpsp_pkg::t_tick i_tick,
    input  logic [5:0]      i_min_delay,
    input  logic [7:0]      i_divisor,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_valid,
    output tpsp_pkg::t_res  o_res,
    output logic [5:0]      o_delay
);
    import tpsp_pkg::*;

    t_stage     r_s0, r_s1, r_s2;
    t_stage     n_s1, n_s2, fin;
    logic [2:0] r_v;
    logic       r_ov;
    t_res       r_res;
    logic [5:0] r_out_delay;
    logic [5:0] r_delay;
    logic [7:0] div;
    logic [5:0] speed;
    logic [5:0] n_delay;
    logic [5:0] dly;
    logic       free0, free1, free2, free3;

    // One restoring step for quotient bit idx.
    function automatic t_stage f_step(input t_stage st, input logic [7:0] d,
                                      input logic [2:0] idx);
        logic [13:0] sh;
        t_stage      r;
        r  = st;
        sh = {6'b0, d} << idx;
        if ({4'b0, st.rem} >= sh) begin
            r.rem      = st.rem - sh[9:0];
            r.quo[idx] = 1'b1;
        end
        return r;
    endfunction

    // A divisor of zero counts as one.
    assign div = (i_divisor == 8'd0) ? 8'd1 : i_divisor;

    // Stage space: a stage is free when empty or moving on.
    assign free3      = !r_ov || i_out_ready;
    assign free2      = !r_v[2] || free3;
    assign free1      = !r_v[1] || free2;
    assign free0      = !r_v[0] || free1;
    assign o_in_ready = free0;

    // Saturation check and the top two quotient bits.
    always_comb begin
        n_s1     = r_s0;
        n_s1.sat = ({4'b0, r_s0.rem} >= {div, 6'b0});
        n_s1     = f_step(n_s1, div, 3'd5);
        n_s1     = f_step(n_s1, div, 3'd4);
    end

    // Middle two quotient bits.
    always_comb begin
        n_s2 = f_step(r_s1, div, 3'd3);
        n_s2 = f_step(n_s2, div, 3'd2);
    end

    // Last two bits, saturation and the lower limit.
    always_comb begin
        fin     = f_step(r_s2, div, 3'd1);
        fin     = f_step(fin, div, 3'd0);
        speed   = fin.sat ? SPEED_MAX : fin.quo;
        n_delay = (speed > i_min_delay) ? speed : i_min_delay;
        dly     = fin.upd ? n_delay : r_delay;
    end

    // Stage valids, the held step delay and the result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 3'b000;
            r_ov    <= 1'b0;
            r_delay <= DELAY_RST;
        end else begin
            if (free0) r_v[0] <= i_load;
            if (free1) r_v[1] <= r_v[0];
            if (free2) r_v[2] <= r_v[1];
            if (free3) r_ov   <= r_v[2];
            if (free3 && r_v[2] && fin.upd) begin
                r_delay <= n_delay;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (free0 && i_load) begin
            r_s0.res <= i_tick.res;
            r_s0.upd <= i_tick.upd;
            r_s0.rem <= i_tick.speed;
            r_s0.quo <= 6'd0;
            r_s0.sat <= 1'b0;
        end
        if (free1 && r_v[0]) r_s1 <= n_s1;
        if (free2 && r_v[1]) r_s2 <= n_s2;
        if (free3 && r_v[2]) begin
            r_res       <= fin.res;
            r_out_delay <= dly;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign o_delay = r_out_delay;

endmodule

FILE: rtl/teach_playback_stepper_positioner_top.sv
// ----------------------------------------------------------------------------
// teach_playback_stepper_positioner_top: three-axis teach-and-playback stepper
// Path: an accepted item passes stages s0, s1, s2, then the result register.
// Throughput: one item per cycle unless the result channel stalls; the mode
// machine settles each accepted item and the three-stage speed divider follows.
// Reset: synchronous, active low; control state, valids and configuration take
// reset values with no clearing pass; the pipe payload registers keep theirs.
// ----------------------------------------------------------------------------
module teach_playback_stepper_positioner_top #(
    parameter int AXES       = 3,
    parameter int POSE_SLOTS = 3,
    parameter int POS_BITS   = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tpsp_in_if.sink         i_item,
    tpsp_out_if.source      o_res,
    tpsp_cfg_if.sink        i_cfg
);
    import tpsp_pkg::*;

    logic [3:0] r_deadband;
    logic [5:0] r_min_delay;
    logic [7:0] r_divisor;
    t_item      item;
    t_tick      tick;
    t_res       res;
    logic [5:0] delay;
    logic       in_ready;
    logic       accept;
    logic       out_valid;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= DEADBAND_RST;
            r_min_delay <= MIN_DELAY_RST;
            r_divisor   <= DIVISOR_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEADBAND:  r_deadband  <= i_cfg.data[3:0];
                CFG_MIN_DELAY: r_min_delay <= i_cfg.data[5:0];
                CFG_DIVISOR:   r_divisor   <= i_cfg.data;
                default:       r_deadband  <= r_deadband;
            endcase
        end
    end

    // Input item.
    always_comb begin
        item.pot_one    = i_item.pot_one;
        item.pot_two    = i_item.pot_two;
        item.pot_three  = i_item.pot_three;
        item.save_level = i_item.save_level;
        item.run_level  = i_item.run_level;
        item.stop_level = i_item.stop_level;
    end

    assign i_item.ready = in_ready;
    assign accept       = i_item.valid && in_ready;

    tpsp_ctrl #(
        .AXES       (AXES),
        .POSE_SLOTS (POSE_SLOTS),
        .POS_BITS   (POS_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (item),
        .i_deadband (r_deadband),
        .o_tick     (tick)
    );

    tpsp_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_tick      (tick),
        .i_min_delay (r_min_delay),
        .i_divisor   (r_divisor),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_valid     (out_valid),
        .o_res       (res),
        .o_delay     (delay)
    );

    // Result item.
    assign o_res.valid          = out_valid;
    assign o_res.coils_one      = res.coils_one;
    assign o_res.coils_two      = res.coils_two;
    assign o_res.coils_three    = res.coils_three;
    assign o_res.step_delay_ms  = delay;
    assign o_res.lamps          = res.lamps;
    assign o_res.gripper_closed = res.gripper_closed;
    assign o_res.mode_now       = res.mode_now;
    assign o_res.arrived_mask   = res.arrived_mask;

endmodule

FILE: rtl/tpsp_chk.sv
// ----------------------------------------------------------------------------
// tpsp_chk: port checker for the teach-and-playback positioner
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module tpsp_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [3:0] i_coils_one,
    input logic [3:0] i_coils_two,
    input logic [3:0] i_coils_three,
    input logic [5:0] i_step_delay_ms,
    input logic [2:0] i_lamps,
    input logic       i_gripper_closed,
    input logic [2:0] i_mode_now,
    input logic [2:0] i_arrived_mask
);
    import tpsp_pkg::*;

    // A result item that is not taken stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result valid dropped while stalled");

    // A stalled result item keeps its fields.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_coils_one) && $stable(i_coils_two) &&
            $stable(i_coils_three) && $stable(i_step_delay_ms) && $stable(i_lamps) &&
            $stable(i_gripper_closed) && $stable(i_mode_now) &&
            $stable(i_arrived_mask))
        else $error("stalled result item changed");

    // While halted, every lamp is dark.
    a_halt_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_mode_now == MODE_SHOWN_HALTED) |-> (i_lamps == 3'd0))
        else $error("lamps lit while halted");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind teach_playback_stepper_positioner_top tpsp_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_res.valid),
    .i_ready          (o_res.ready),
    .i_coils_one      (o_res.coils_one),
    .i_coils_two      (o_res.coils_two),
    .i_coils_three    (o_res.coils_three),
    .i_step_delay_ms  (o_res.step_delay_ms),
    .i_lamps          (o_res.lamps),
    .i_gripper_closed (o_res.gripper_closed),
    .i_mode_now       (o_res.mode_now),
    .i_arrived_mask   (o_res.arrived_mask)
);
